FILE: rtl/assert_macros.svh
// Assertion macros used by the peak window extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/wpwe_pkg.sv
`timescale 1ns / 1ps

package wpwe_pkg;

  // Samples in one waveform when no last-sample mark cuts it short.
  localparam int WAVEFORM_LENGTH = 20;

  localparam int SAMPLE_W = 8;
  localparam int IDX_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // First sample index at which a full five-sample window is available.
  localparam logic [IDX_W-1:0] FIRST_CHECK_IDX = IDX_W'(4);
  localparam logic [IDX_W-1:0] LAST_IDX        = IDX_W'(WAVEFORM_LENGTH - 1);

  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET = 8'd40;
  localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RESET    = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_LOW_THRESHOLD = 2'd0,
    REG_PEAK_HIGH_LIMIT    = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                skip_waveform;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] before_two;
    logic [SAMPLE_W-1:0] before_one;
    logic [SAMPLE_W-1:0] peak_value;
    logic [SAMPLE_W-1:0] after_one;
    logic [SAMPLE_W-1:0] after_two;
    logic [IDX_W-1:0]    peak_position;
  } out_item_t;

  // Five samples centered on a peak candidate, in waveform order.
  typedef struct packed {
    logic [SAMPLE_W-1:0] before_two;
    logic [SAMPLE_W-1:0] before_one;
    logic [SAMPLE_W-1:0] center;
    logic [SAMPLE_W-1:0] after_one;
    logic [SAMPLE_W-1:0] after_two;
  } window_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low_threshold;
    logic [SAMPLE_W-1:0] high_limit;
  } thresholds_t;

endpackage

FILE: rtl/wpwe_peak_check.sv
`timescale 1ns / 1ps

module wpwe_peak_check
  import wpwe_pkg::*;
(
  input  window_t     window,
  input  thresholds_t limits,
  output logic        is_peak
);

  logic in_band;
  logic rising;
  logic falling;

  // The center must lie strictly between the two thresholds.
  assign in_band = (window.center > limits.low_threshold) &&
                   (window.center < limits.high_limit);

  // Strict rise over the two samples before and strict fall over the two after.
  assign rising  = (window.before_two < window.before_one) &&
                   (window.before_one < window.center);
  assign falling = (window.center > window.after_one) &&
                   (window.after_one > window.after_two);

  assign is_peak = in_band && rising && falling;

endmodule

FILE: rtl/waveform_peak_window_extractor.sv
`timescale 1ns / 1ps
// Finds the first strict local peak within the thresholds in each waveform.
// Input channel: one sample item per accepted cycle, carrying the amplitude, a
// skip flag and a last-sample mark. A waveform ends at the marked sample or
// after WAVEFORM_LENGTH samples, whichever comes first.
// Output channel: at most one item per waveform, holding the five samples around
// the peak and the peak's index. It is loaded when the second sample after the
// peak is accepted and issued from the result register in the next cycle.
// Throughput: one sample per cycle unless the full result register stalls. The
// window compare runs between the history and result registers; nothing iterates.
// The cfg port writes the low threshold and high limit; indexes above the list
// are ignored. Write it only while no samples are in flight.
// Reset clears the history, the waveform position, the peak-found flag and the
// output valid, and loads the threshold defaults.
// While the receiver stalls, the result register holds its item; input is
// still taken unless that register is full and stalled.

module waveform_peak_window_extractor
  import wpwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  thresholds_t         limits;
  logic [SAMPLE_W-1:0] recent [4];
  logic [IDX_W-1:0]    sample_index;
  logic                peak_found;

  logic        in_accept;
  logic        out_take;
  logic        waveform_done;
  logic        wave_end;
  logic        is_peak;
  logic        load_result;
  window_t     window;
  logic [IDX_W-1:0] sample_index_next;
  logic        peak_found_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.low_threshold <= LOW_THRESHOLD_RESET;
      limits.high_limit    <= HIGH_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PEAK_LOW_THRESHOLD: limits.low_threshold <= cfg_data;
        REG_PEAK_HIGH_LIMIT:    limits.high_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees up in the same cycle it is taken.
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Window of the four previous samples plus the one that completes it.
  assign window.before_two = recent[3];
  assign window.before_one = recent[2];
  assign window.center     = recent[1];
  assign window.after_one  = recent[0];
  assign window.after_two  = in_item.sample;

  wpwe_peak_check u_peak_check (
    .window  (window),
    .limits  (limits),
    .is_peak (is_peak)
  );

  // A skipped waveform, or one whose peak is already found, gives no more results.
  assign waveform_done = peak_found || in_item.skip_waveform;
  assign load_result   = in_accept && !waveform_done &&
                         (sample_index >= FIRST_CHECK_IDX) && is_peak;
  assign wave_end      = in_item.last_sample || (sample_index >= LAST_IDX);

  always_comb begin
    if (wave_end) begin
      sample_index_next = '0;
      peak_found_next   = 1'b0;
    end else begin
      sample_index_next = sample_index + IDX_W'(1);
      peak_found_next   = waveform_done || load_result;
    end
  end

  // Waveform position and sample history.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      peak_found   <= 1'b0;
      recent[0]    <= '0;
      recent[1]    <= '0;
      recent[2]    <= '0;
      recent[3]    <= '0;
    end else if (in_accept) begin
      sample_index <= sample_index_next;
      peak_found   <= peak_found_next;
      recent[0]    <= in_item.sample;
      recent[1]    <= recent[0];
      recent[2]    <= recent[1];
      recent[3]    <= recent[2];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_item.before_two    <= window.before_two;
      out_item.before_one    <= window.before_one;
      out_item.peak_value    <= window.center;
      out_item.after_one     <= window.after_one;
      out_item.after_two     <= window.after_two;
      out_item.peak_position <= sample_index - IDX_W'(2);
    end
  end

  `ASSERT_ALWAYS(a_index_range, rst || sample_index <= LAST_IDX, "sample index past waveform end")
  `ASSERT_CLK(a_one_result_per_wave, load_result |=> peak_found || sample_index == '0, "peak flag not set after result")
  `ASSERT_CLK(a_result_is_peak, out_valid |-> (out_item.before_two < out_item.before_one && out_item.peak_value > out_item.after_one && out_item.after_one > out_item.after_two), "result window is not a peak")
  `ASSERT_CLK(a_position_range, out_valid |-> (out_item.peak_position >= IDX_W'(2) && out_item.peak_position <= LAST_IDX - IDX_W'(2)), "peak position out of range")

endmodule

FILE: tb/peak_window_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the peak window extractor. It keeps its own copy of
// the waveform state and thresholds, predicts the window of each peak it sees in
// the accepted samples, and compares each result item with the oldest prediction.
module peak_window_checker
  import wpwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    results
);

  // The peak sits two samples behind the sample that completes its window.
  localparam logic [IDX_W-1:0] PEAK_LAG = IDX_W'(2);

  logic [SAMPLE_W-1:0] low_thr;
  logic [SAMPLE_W-1:0] high_lim;
  logic [SAMPLE_W-1:0] recent [4];
  logic [IDX_W-1:0]    wave_pos;
  logic                wave_done;
  out_item_t           expected_windows [$];
  out_item_t           want;
  logic                bad;

  // Advances the waveform state by one sample and queues the window it completes if it holds a peak.
  function automatic void predict_sample(input in_item_t it);
    out_item_t        win;
    logic [IDX_W-1:0] pos;
    pos = wave_pos;
    if (it.skip_waveform) begin
      wave_done = 1'b1;
    end
    if (!wave_done && pos >= FIRST_CHECK_IDX) begin
      if (recent[1] > low_thr && recent[1] < high_lim &&
          recent[3] < recent[2] && recent[2] < recent[1] &&
          recent[1] > recent[0] && recent[0] > it.sample) begin
        win.before_two    = recent[3];
        win.before_one    = recent[2];
        win.peak_value    = recent[1];
        win.after_one     = recent[0];
        win.after_two     = it.sample;
        win.peak_position = pos - PEAK_LAG;
        expected_windows.insert(expected_windows.size(), win);
        wave_done = 1'b1;
      end
    end
    recent[3] = recent[2];
    recent[2] = recent[1];
    recent[1] = recent[0];
    recent[0] = it.sample;
    // The waveform ends at the marked sample or at its full length.
    if (it.last_sample || pos >= LAST_IDX) begin
      wave_pos  = '0;
      wave_done = 1'b0;
    end else begin
      wave_pos = pos + IDX_W'(1);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      low_thr  = LOW_THRESHOLD_RESET;
      high_lim = HIGH_LIMIT_RESET;
      for (int i = 0; i < 4; i++) recent[i] = '0;
      wave_pos  = '0;
      wave_done = 1'b0;
      errors    = 0;
      results   = 0;
      expected_windows.delete();
    end else begin
      // A result leaving now comes from an earlier sample, so check it first.
      if (out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected peak window %0d %0d %0d %0d %0d at %0d", $time,
                     out_item.before_two, out_item.before_one, out_item.peak_value,
                     out_item.after_one, out_item.after_two, out_item.peak_position);
          end
        end else begin
          want = expected_windows.pop_front();
          results++;
          bad = (out_item.before_two !== want.before_two) ||
                (out_item.before_one !== want.before_one) ||
                (out_item.peak_value !== want.peak_value) ||
                (out_item.after_one !== want.after_one) ||
                (out_item.after_two !== want.after_two) ||
                (out_item.peak_position !== want.peak_position);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: peak window mismatch, expected %0d %0d %0d %0d %0d at %0d",
                       $time, want.before_two, want.before_one, want.peak_value,
                       want.after_one, want.after_two, want.peak_position);
              $display("%0t:                       got      %0d %0d %0d %0d %0d at %0d",
                       $time, out_item.before_two, out_item.before_one,
                       out_item.peak_value, out_item.after_one, out_item.after_two,
                       out_item.peak_position);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_sample(in_item);
      end
      // Writes to indexes outside the register list are ignored.
      if (cfg_write) begin
        case (cfg_index)
          REG_PEAK_LOW_THRESHOLD: low_thr = cfg_data;
          REG_PEAK_HIGH_LIMIT:    high_lim = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_windows.size();
  end

endmodule

FILE: tb/tb_waveform_peak_window_extractor.sv
`timescale 1ns / 1ps

module tb_waveform_peak_window_extractor;
  import wpwe_pkg::*;

  localparam int N_PHASES    = 7;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  // An index past the register list, used to check that such writes are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int results;

  int tx_idle_pct = 12;
  int rx_idle_pct = 47;
  int hold_requests = 0;
  int hold_started = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_samples = 0;
  int n_waves = 0;
  int cur_low = 40;
  int cur_high = 255;

  // Threshold settings and sample budget of each phase.
  int phase_low   [N_PHASES] = '{0, 100, 255, 200, 0, 10, 40};
  int phase_high  [N_PHASES] = '{255, 200, 0, 255, 1, 250, 255};
  int phase_items [N_PHASES] = '{100, 100, 60, 100, 60, 110, 110};

  logic [SAMPLE_W-1:0] wave_buf [WAVEFORM_LENGTH];
  logic                skip_buf [WAVEFORM_LENGTH];

  waveform_peak_window_extractor u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  peak_window_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .results   (results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_waveform_peak_window_extractor: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold whenever one is requested.
  always @(negedge clk) begin
    if (hold_started != hold_requests) begin
      hold_started <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
    end
  end

  // Offers one sample item, with random gaps, and returns once it is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic skip,
                             input logic last);
    in_item_t it;
    it.sample        = s;
    it.skip_waveform = skip;
    it.last_sample   = last;
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_samples++;
  endtask

  // Drops valid and waits until every expected window has come out.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_thresholds(input int low, input int high, input bit poke_unused);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_PEAK_LOW_THRESHOLD;
    cfg_data  <= low[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= REG_PEAK_HIGH_LIMIT;
    cfg_data  <= high[CFG_DATA_W-1:0];
    if (poke_unused) begin
      @(negedge clk);
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_DATA_W'($urandom_range(255, 0));
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_low  = low;
    cur_high = high;
  endtask

  // Fills the waveform buffer. Most waveforms carry a peak shaped to pass the
  // current thresholds where they allow one, some of them skipped; the rest are noise or cut very short.
  task automatic make_wave(output int len, output logic cut);
    int kind;
    int p;
    int pk;
    int b1;
    int b2;
    int a1;
    int a2;
    int lo;
    int hi;
    kind = $urandom_range(99, 0);
    for (int i = 0; i < WAVEFORM_LENGTH; i++) begin
      wave_buf[i] = SAMPLE_W'($urandom_range(255, 0));
      skip_buf[i] = 1'b0;
    end
    if (kind >= 92) begin
      // Broken waveform: ends before any window can be tested.
      cut = 1'b1;
      len = $urandom_range(4, 1);
    end else begin
      cut = 1'($urandom_range(1, 0));
      len = cut ? $urandom_range(WAVEFORM_LENGTH, 5) : WAVEFORM_LENGTH;
    end
    if (kind < 82 && kind >= 70) begin
      return;
    end
    if (kind < 92) begin
      lo = (cur_low + 1 > 2) ? cur_low + 1 : 2;
      hi = cur_high - 1;
      pk = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(255, 2);
      b1 = $urandom_range(pk - 1, 1);
      b2 = $urandom_range(b1 - 1, 0);
      a1 = $urandom_range(pk - 1, 1);
      a2 = $urandom_range(a1 - 1, 0);
      p  = $urandom_range(len - 3, 2);
      wave_buf[p-2] = b2[SAMPLE_W-1:0];
      wave_buf[p-1] = b1[SAMPLE_W-1:0];
      wave_buf[p]   = pk[SAMPLE_W-1:0];
      wave_buf[p+1] = a1[SAMPLE_W-1:0];
      wave_buf[p+2] = a2[SAMPLE_W-1:0];
    end
    // Skipped waveform: the flag on every sample or on one of them.
    if (kind >= 82 && kind < 92) begin
      if ($urandom_range(1, 0) == 1) begin
        for (int i = 0; i < len; i++) skip_buf[i] = 1'b1;
      end else begin
        skip_buf[$urandom_range(len - 1, 0)] = 1'b1;
      end
    end
  endtask

  task automatic send_wave(input int len, input logic cut);
    for (int i = 0; i < len; i++) begin
      send_sample(wave_buf[i], skip_buf[i], cut && (i == len - 1));
    end
    n_waves++;
  endtask

  initial begin
    int   len;
    logic cut;
    int   phase_start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed waveforms at the reset thresholds.
    // Peak at the earliest position with the largest value that passes.
    send_sample(8'd100, 1'b0, 1'b0);
    send_sample(8'd200, 1'b0, 1'b0);
    send_sample(8'd254, 1'b0, 1'b0);
    send_sample(8'd100, 1'b0, 1'b0);
    send_sample(8'd0,   1'b0, 1'b1);
    // Peak equal to the low threshold does not count.
    send_sample(8'd0,   1'b0, 1'b0);
    send_sample(8'd20,  1'b0, 1'b0);
    send_sample(8'd40,  1'b0, 1'b0);
    send_sample(8'd30,  1'b0, 1'b0);
    send_sample(8'd10,  1'b0, 1'b0);
    send_sample(8'd5,   1'b0, 1'b1);
    // Skipped waveform that would otherwise hold a valid peak.
    send_sample(8'd255, 1'b1, 1'b0);
    send_sample(8'd1,   1'b0, 1'b0);
    send_sample(8'd2,   1'b0, 1'b0);
    send_sample(8'd200, 1'b0, 1'b0);
    send_sample(8'd100, 1'b0, 1'b0);
    send_sample(8'd50,  1'b0, 1'b1);
    // Waveform cut short before a full window, then a one-sample waveform
    // that starts on stale history.
    send_sample(8'd1,   1'b0, 1'b0);
    send_sample(8'd2,   1'b0, 1'b0);
    send_sample(8'd200, 1'b0, 1'b0);
    send_sample(8'd100, 1'b0, 1'b1);
    send_sample(8'd255, 1'b0, 1'b1);
    n_waves += 5;

    // Random phases, each under its own thresholds and one of three idle patterns.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      if (ph < 3) begin
        tx_idle_pct = 12;
        rx_idle_pct = 47;
      end else if (ph < 5) begin
        tx_idle_pct = 47;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_thresholds(phase_low[ph], phase_high[ph], ph == 2);
      if (ph == 1 || ph == 4) begin
        hold_requests++;
      end
      phase_start = n_samples;
      while (n_samples - phase_start < phase_items[ph]) begin
        make_wave(len, cut);
        send_wave(len, cut);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d samples in %0d waveforms under %0d threshold settings.",
             n_samples, n_waves, N_PHASES + 1);
    $display("Checked %0d peak windows with sender-heavy, receiver-heavy and no idling.",
             results);
    if (errors == 0 && pending == 0) begin
      $display("tb_waveform_peak_window_extractor: done, clean");
    end else begin
      $display("tb_waveform_peak_window_extractor: done, errors");
    end
    $finish;
  end

endmodule
